### hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// Feistel block cipher package
// Shared widths, cipher constants, register indexes and the request type
// that the control sequencer sends to the shared mixing unit.
// ----------------------------------------------------------------------------
package fbc_pkg;

  // Block and key geometry.
  localparam int HALF_W      = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 1;

  // Number of Feistel rounds, and hence the depth of the round key store.
  localparam int ROUND_COUNT = 16;
  localparam int KEY_IDX_W   = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
  localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(ROUND_COUNT - 1);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

  // Round function multipliers.
  localparam logic [HALF_W-1:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [HALF_W-1:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;

  // Key schedule seeding and sequence constants.
  localparam logic [HALF_W-1:0] SEED_MUL = 64'h2545f4914f6cdd1d;
  localparam logic [HALF_W-1:0] SEED_XOR = 64'hd1b54a32d192ed03;
  localparam logic [HALF_W-1:0] SQ_STEP  = 64'h9e3779b97f4a7c15;
  localparam logic [HALF_W-1:0] SQ_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [HALF_W-1:0] SQ_MUL_B = 64'h94d049bb133111eb;

  // Operations of the mixing unit.
  typedef enum logic [1:0] {
    OP_ROUND = 2'd0,  // Feistel round function
    OP_SEQ   = 2'd1,  // key sequence output step
    OP_SEED  = 2'd2   // key sequence seed
  } mix_op_t;

  // Control request from the sequencer to the mixing unit.
  typedef struct packed {
    logic    start;
    logic    flush;
    mix_op_t op;
  } mix_req_t;

endpackage

### hdl/fbc_in_if.sv
// ----------------------------------------------------------------------------
// Feistel block cipher input channel
// Carries one block and its mode bit with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbc_in_if import fbc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              mode;
  logic [HALF_W-1:0] block_low;
  logic [HALF_W-1:0] block_high;

  modport source (output valid, output mode, output block_low, output block_high,
                  input ready);
  modport sink   (input valid, input mode, input block_low, input block_high,
                  output ready);

endinterface

### hdl/fbc_out_if.sv
// ----------------------------------------------------------------------------
// Feistel block cipher output channel
// Carries one result block with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fbc_out_if import fbc_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] result_low;
  logic [HALF_W-1:0] result_high;

  modport source (output valid, output result_low, output result_high, input ready);
  modport sink   (input valid, input result_low, input result_high, output ready);

endinterface

### hdl/fbc_mix.sv
// ----------------------------------------------------------------------------
// Feistel block cipher mixing unit
// Shared multi-cycle unit for the round function, the key sequence step and
// the key seed. Each 64-bit product is built from 32-bit partial products,
// registered in a partial-product state and summed in a combine state.
// ----------------------------------------------------------------------------
module fbc_mix import fbc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mix_req_t          req,
  input  logic [HALF_W-1:0] x,
  input  logic [HALF_W-1:0] k,
  output logic              done,
  output logic [HALF_W-1:0] y
);

  typedef enum logic [5:0] {
    M_IDLE = 6'b000001,
    M_P1   = 6'b000010,
    M_S1   = 6'b000100,
    M_P2   = 6'b001000,
    M_S2   = 6'b010000,
    M_FIN  = 6'b100000
  } mix_state_t;

  mix_state_t        state;
  mix_op_t           op;
  logic [HALF_W-1:0] v;
  logic [HALF_W-1:0] kadd;
  logic [HALF_W-1:0] pp_ll;
  logic [31:0]       pp_x;

  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_c;
  logic [HALF_W-1:0] pp_ll_next;
  logic [31:0]       pp_x_next;

  // Operand selection: the xor-shift, if any, in front of each multiply, and its constant.
  always_comb begin
    mul_a = v;
    mul_c = SEED_MUL;
    case (op)
      OP_ROUND: begin
        mul_a = v ^ (v >> 33);
        mul_c = (state == M_P2) ? MIX_MUL_B : MIX_MUL_A;
      end
      OP_SEQ: begin
        mul_a = (state == M_P2) ? (v ^ (v >> 27)) : (v ^ (v >> 30));
        mul_c = (state == M_P2) ? SQ_MUL_B : SQ_MUL_A;
      end
      OP_SEED: begin
        mul_a = v;
        mul_c = SEED_MUL;
      end
      default: begin
        mul_a = v;
        mul_c = SEED_MUL;
      end
    endcase
  end

  // Partial products of the low 64 bits of the product.
  always_comb begin
    pp_ll_next = {32'b0, mul_a[31:0]} * {32'b0, mul_c[31:0]};
    pp_x_next  = mul_a[31:0] * mul_c[63:32] + mul_a[63:32] * mul_c[31:0];
  end

  // Final step of each operation.
  always_comb begin
    case (op)
      OP_ROUND: y = (v ^ (v >> 33)) + kadd;
      OP_SEQ:   y = v ^ (v >> 31);
      OP_SEED:  y = v ^ kadd;
      default:  y = v;
    endcase
  end

  assign done = (state == M_FIN);

  // Sequencing of the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      op    <= OP_ROUND;
    end else if (req.flush) begin
      state <= M_IDLE;
    end else begin
      case (state)
        M_IDLE: begin
          if (req.start) begin
            op    <= req.op;
            state <= M_P1;
          end
        end
        M_P1:    state <= M_S1;
        M_S1:    state <= (op == OP_SEED) ? M_FIN : M_P2;
        M_P2:    state <= M_S2;
        M_S2:    state <= M_FIN;
        M_FIN:   state <= M_IDLE;
        default: state <= M_IDLE;
      endcase
    end
  end

  // Working value and partial product registers.
  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (req.start) begin
          v    <= (req.op == OP_ROUND) ? (x + k) : x;
          kadd <= k;
        end
      end
      M_P1, M_P2: begin
        pp_ll <= pp_ll_next;
        pp_x  <= pp_x_next;
      end
      M_S1, M_S2: v <= pp_ll + {pp_x, 32'b0};
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_flush_idles: assert property (@(posedge clk) disable iff (rst)
    req.flush |=> state == M_IDLE)
    else $error("mixing unit did not return to idle after a flush");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (state == M_IDLE && req.start && !req.flush) |=> state == M_P1)
    else $error("mixing unit ignored a start request");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("mixing unit held its result for more than one cycle");
`endif

endmodule

### hdl/feistel_block_cipher_128_unit.sv
// ----------------------------------------------------------------------------
// Feistel block cipher, 128-bit block
// Sixteen-round balanced Feistel cipher with a round key store in memory.
// ----------------------------------------------------------------------------
// One block is accepted at a time; the next is accepted only after the first
// round key is read, the sixteen rounds run, the output register is loaded
// (this waits while an earlier result is still held there) and the sequencer
// is back in idle. Each round is timed by the shared mixing unit, whose two
// 64-bit multiplies each go through a partial-product state and a combine
// state. After reset and after every key register write the round key store
// is rederived, one key at a time after a seed step, and the block accepts no
// request until the last key is written. A finished result waits in the output
// register while the next request is accepted.
// ----------------------------------------------------------------------------
module feistel_block_cipher_128_unit import fbc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  fbc_in_if.sink                 blk_in,
  fbc_out_if.source              blk_out
);

  typedef enum logic [8:0] {
    S_SEED_GO   = 9'b000000001,
    S_SEED_WAIT = 9'b000000010,
    S_KEY_GO    = 9'b000000100,
    S_KEY_WAIT  = 9'b000001000,
    S_IDLE      = 9'b000010000,
    S_RD        = 9'b000100000,
    S_RND_GO    = 9'b001000000,
    S_RND_WAIT  = 9'b010000000,
    S_OUT       = 9'b100000000
  } ctl_state_t;

  ctl_state_t           state;
  logic [HALF_W-1:0]    key_low;
  logic [HALF_W-1:0]    key_high;
  logic [HALF_W-1:0]    ctr;
  logic [KEY_IDX_W-1:0] idx;
  logic [KEY_IDX_W-1:0] rnd;
  logic                 decrypt;
  logic [HALF_W-1:0]    left;
  logic [HALF_W-1:0]    right;
  logic                 out_valid;
  logic [HALF_W-1:0]    out_low;
  logic [HALF_W-1:0]    out_high;

  // Round key store: written while the schedule is derived, read during rounds.
  logic [HALF_W-1:0]    key_mem [ROUND_COUNT];
  logic [HALF_W-1:0]    rd_data;

  mix_req_t             mix_req;
  logic [HALF_W-1:0]    mix_x;
  logic [HALF_W-1:0]    mix_k;
  logic                 mix_done;
  logic [HALF_W-1:0]    mix_y;

  logic                 in_accept;
  logic                 key_we;
  logic                 out_free;
  logic                 load_out;

  // Handshake decode. A key write takes priority over a new request.
  assign blk_in.ready = (state == S_IDLE) && !cfg_write;
  assign in_accept    = blk_in.valid && blk_in.ready;
  assign key_we       = (state == S_KEY_WAIT) && mix_done && !cfg_write;
  assign out_free     = !out_valid || blk_out.ready;
  assign load_out     = (state == S_OUT) && out_free && !cfg_write;

  // Requests to the mixing unit. A key write aborts any work in progress.
  always_comb begin
    mix_req.start = 1'b0;
    mix_req.flush = cfg_write;
    mix_req.op    = OP_ROUND;
    mix_x         = decrypt ? left : right;
    mix_k         = rd_data;
    case (state)
      S_SEED_GO: begin
        mix_req.start = 1'b1;
        mix_req.op    = OP_SEED;
        mix_x         = key_high;
        mix_k         = key_low ^ SEED_XOR;
      end
      S_KEY_GO: begin
        mix_req.start = 1'b1;
        mix_req.op    = OP_SEQ;
        mix_x         = ctr;
        mix_k         = '0;
      end
      S_RND_GO: begin
        mix_req.start = 1'b1;
        mix_req.op    = OP_ROUND;
      end
      default: ;
    endcase
  end

  fbc_mix u_mix (
    .clk  (clk),
    .rst  (rst),
    .req  (mix_req),
    .x    (mix_x),
    .k    (mix_k),
    .done (mix_done),
    .y    (mix_y)
  );

  // Key store port. Writes happen only while deriving. The read is registered
  // unconditionally from idx, and its data is used only while a block is in flight.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[idx] <= mix_y;
    end
    rd_data <= key_mem[idx];
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_SEED_GO;
      key_low  <= '0;
      key_high <= '0;
      idx      <= '0;
      rnd      <= '0;
      decrypt  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
      state <= S_SEED_GO;
    end else begin
      case (state)
        S_SEED_GO: state <= S_SEED_WAIT;
        S_SEED_WAIT: begin
          if (mix_done) begin
            idx   <= '0;
            state <= S_KEY_GO;
          end
        end
        S_KEY_GO: state <= S_KEY_WAIT;
        S_KEY_WAIT: begin
          if (mix_done) begin
            if (idx == LAST_KEY) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_KEY_GO;
            end
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            decrypt <= blk_in.mode;
            idx     <= blk_in.mode ? LAST_KEY : '0;
            rnd     <= '0;
            state   <= S_RD;
          end
        end
        S_RD: state <= S_RND_GO;
        S_RND_GO: begin
          // Fetch the next key while the round runs.
          if (rnd != LAST_KEY) begin
            idx <= decrypt ? (idx - 1'b1) : (idx + 1'b1);
          end
          state <= S_RND_WAIT;
        end
        S_RND_WAIT: begin
          if (mix_done) begin
            if (rnd == LAST_KEY) begin
              state <= S_OUT;
            end else begin
              rnd   <= rnd + 1'b1;
              state <= S_RND_GO;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Sequence counter and block halves.
  always_ff @(posedge clk) begin
    if (state == S_SEED_WAIT && mix_done) begin
      ctr <= mix_y + SQ_STEP;
    end else if (key_we) begin
      ctr <= ctr + SQ_STEP;
    end
    if (in_accept) begin
      left  <= blk_in.block_low;
      right <= blk_in.block_high;
    end else if (state == S_RND_WAIT && mix_done) begin
      if (decrypt) begin
        left  <= right ^ mix_y;
        right <= left;
      end else begin
        left  <= right;
        right <= left ^ mix_y;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (blk_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_low  <= left;
      out_high <= right;
    end
  end

  assign blk_out.valid       = out_valid;
  assign blk_out.result_low  = out_low;
  assign blk_out.result_high = out_high;

`ifndef SYNTHESIS
  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    (blk_in.valid && blk_in.ready) |=> state == S_RD)
    else $error("accepted request did not start a key read");

  a_key_write_rederives: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> state == S_SEED_GO)
    else $error("key write did not restart the key schedule");

  a_done_awaited: assert property (@(posedge clk) disable iff (rst)
    mix_done |-> (state == S_SEED_WAIT || state == S_KEY_WAIT || state == S_RND_WAIT))
    else $error("mixing unit finished while the sequencer was not waiting");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> blk_out.valid)
    else $error("finished block did not reach the output register");
`endif

endmodule

### tb/feistel_block_cipher_128_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feistel block cipher, 128-bit block: self-checking testbench
// Sends blocks in both modes under several master keys, with random gaps on
// the request side and random back-pressure on the result side, including
// one long hold-off that backs the block up. Every result is compared with
// the output of a local cipher model that keeps its own round key schedule.
// ----------------------------------------------------------------------------
module feistel_block_cipher_128_unit_tb import fbc_pkg::*; ();

  // Mode bit values on the request channel.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Cipher geometry and constants, kept here independently of the design.
  localparam int          ROUNDS     = 16;
  localparam logic [63:0] FMIX_MUL_1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_MUL_2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] SEED_MULT  = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] SEED_MASK  = 64'hd1b54a32d192ed03;
  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SCRAMBLE_1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SCRAMBLE_2 = 64'h94d049bb133111eb;

  // Idle time after the last result before a key write or the end of the run.
  localparam int SETTLE_CYCLES = 110;
  // Length of the long result-side hold-off.
  localparam int HOLD_CYCLES   = 600;

  typedef struct packed {
    logic        mode;
    logic [63:0] low;
    logic [63:0] high;
  } block_req_t;

  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } block_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // Locally held request and result-side drive, copied onto the channels.
  logic        in_valid = 1'b0;
  logic        in_mode  = 1'b0;
  logic [63:0] in_low   = '0;
  logic [63:0] in_high  = '0;
  logic        out_ready = 1'b0;

  fbc_in_if  blk_in();
  fbc_out_if blk_out();

  assign blk_in.valid      = in_valid;
  assign blk_in.mode       = in_mode;
  assign blk_in.block_low  = in_low;
  assign blk_in.block_high = in_high;
  assign blk_out.ready     = out_ready;

  feistel_block_cipher_128_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_in    (blk_in),
    .blk_out   (blk_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cipher model state: master key and the derived round keys.
  logic [63:0] model_key_low;
  logic [63:0] model_key_high;
  logic [63:0] round_keys [ROUNDS];

  block_req_t pending_blocks [$];
  block_res_t expected_blocks [$];

  block_req_t next_req;
  block_res_t due_res;
  int         mismatch_count = 0;

  // Idling controls; the enables and hold_go are changed by the stimulus process on falling edges.
  bit     send_idle_on = 1'b0;
  bit     recv_idle_on = 1'b0;
  bit     hold_go      = 1'b0;
  int     hold_left    = 0;
  int     send_gap     = 0;
  int     recv_gap     = 0;

  // Round function: fmix-style mix of one half with a round key.
  function automatic logic [63:0] mix_half(logic [63:0] half, logic [63:0] rk);
    logic [63:0] v;
    v = half + rk;
    v = v ^ (v >> 33);
    v = v * FMIX_MUL_1;
    v = v ^ (v >> 33);
    v = v * FMIX_MUL_2;
    v = v ^ (v >> 33);
    return v + rk;
  endfunction

  // Rebuilds the round keys from the master key with a splitmix64 sequence.
  task automatic derive_round_keys();
    logic [63:0] ctr;
    logic [63:0] z;
    ctr = model_key_low ^ (model_key_high * SEED_MULT) ^ SEED_MASK;
    for (int i = 0; i < ROUNDS; i++) begin
      ctr = ctr + GOLDEN_INC;
      z = ctr;
      z = (z ^ (z >> 30)) * SCRAMBLE_1;
      z = (z ^ (z >> 27)) * SCRAMBLE_2;
      round_keys[i] = z ^ (z >> 31);
    end
  endtask

  // Full Feistel ladder; decryption walks the round keys backwards.
  function automatic block_res_t feistel_cipher(logic mode, logic [63:0] lo,
                                                logic [63:0] hi);
    logic [63:0] left;
    logic [63:0] right;
    logic [63:0] t;
    block_res_t  res;
    left  = lo;
    right = hi;
    if (mode == MODE_ENCRYPT) begin
      for (int i = 0; i < ROUNDS; i++) begin
        t     = left ^ mix_half(right, round_keys[i]);
        left  = right;
        right = t;
      end
    end else begin
      for (int i = ROUNDS - 1; i >= 0; i--) begin
        t     = right ^ mix_half(left, round_keys[i]);
        right = left;
        left  = t;
      end
    end
    res.low  = left;
    res.high = right;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
    mismatch_count++;
  endtask

  // Random word biased towards zero, all ones and single set or clear bits.
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_block(logic mode, logic [63:0] lo, logic [63:0] hi);
    block_req_t req;
    req.mode = mode;
    req.low  = lo;
    req.high = hi;
    pending_blocks.push_back(req);
  endtask

  // Encrypts a block and then asks for the decryption of its ciphertext.
  task automatic queue_round_trip(logic [63:0] lo, logic [63:0] hi);
    block_res_t ct;
    ct = feistel_cipher(MODE_ENCRYPT, lo, hi);
    queue_block(MODE_ENCRYPT, lo, hi);
    queue_block(MODE_DECRYPT, ct.low, ct.high);
  endtask

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        queue_round_trip(rand_word(), rand_word());
        i++;
      end else begin
        queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
      end
    end
  endtask

  // Waits until every request is sent and every result has come back.
  task automatic drain();
    while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_KEY_LOW) begin
      model_key_low = value;
    end else begin
      model_key_high = value;
    end
    derive_round_keys();
    @(negedge clk);
  endtask

  task automatic write_keys(logic [63:0] lo, logic [63:0] hi);
    write_reg(REG_KEY_LOW, lo);
    write_reg(REG_KEY_HIGH, hi);
  endtask

  // Request driver: records the expected result for every accepted request
  // and presents the next pending block, with random gaps while send idling is on.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && blk_in.ready)
        expected_blocks.push_back(feistel_cipher(in_mode, in_low, in_high));
      if (!in_valid || blk_in.ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_blocks.size() == 0) begin
          in_valid <= 1'b0;
        end else if (send_idle_on && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 17);
        end else begin
          next_req = pending_blocks.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_req.mode;
          in_low   <= next_req.low;
          in_high  <= next_req.high;
        end
      end
    end
  end

  // Long hold-off counter for the result side.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: checks each accepted result against the oldest
  // expectation and applies the long hold-off and random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (blk_out.valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("result_low with no request outstanding", '0,
                          blk_out.result_low);
        end else begin
          due_res = expected_blocks.pop_front();
          if (blk_out.result_low !== due_res.low)
            report_mismatch("result_low", due_res.low, blk_out.result_low);
          if (blk_out.result_high !== due_res.high)
            report_mismatch("result_high", due_res.high, blk_out.result_high);
        end
      end
      if (hold_go || hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        recv_gap  <= $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed blocks under the reset key and the extreme keys,
  // then random phases, each under a fresh random key.
  initial begin
    model_key_low  = '0;
    model_key_high = '0;
    derive_round_keys();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extreme halves in both modes under the all-zero reset key.
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    queue_block(MODE_ENCRYPT, '0, '0);
    queue_block(MODE_DECRYPT, '0, '0);
    queue_block(MODE_ENCRYPT, '1, '1);
    queue_block(MODE_DECRYPT, '1, '1);
    queue_block(MODE_ENCRYPT, '0, '1);
    queue_block(MODE_DECRYPT, '1, '0);
    queue_block(MODE_ENCRYPT, 64'h1, 64'h8000_0000_0000_0000);
    queue_block(MODE_DECRYPT, 64'h8000_0000_0000_0000, 64'h1);
    queue_block(MODE_ENCRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    queue_round_trip({$urandom, $urandom}, {$urandom, $urandom});
    drain();

    // A new key takes effect for the very next block.
    write_keys('1, '0);
    queue_block(MODE_ENCRYPT, '0, '0);
    queue_block(MODE_DECRYPT, '1, '1);
    queue_round_trip(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    drain();
    write_keys('1, '1);
    queue_block(MODE_ENCRYPT, '1, '0);
    queue_round_trip('0, '1);
    drain();
    write_keys('0, '1);
    queue_block(MODE_DECRYPT, '0, '0);
    queue_round_trip('1, '1);
    drain();

    // Random phases; one runs with no idling and one with a long stall.
    for (int phase = 0; phase < 6; phase++) begin
      write_keys(rand_word(), rand_word());
      send_idle_on = (phase != 2);
      recv_idle_on = (phase != 2);
      if (phase == 3) begin
        send_idle_on = 1'b0;
        hold_go = 1'b1;
        @(negedge clk);
        hold_go = 1'b0;
        queue_random(170);
        while (hold_left != 0) @(negedge clk);
        send_idle_on = 1'b1;
      end else begin
        queue_random(170);
      end
      drain();
    end

    // Closing phase at full rate on both sides.
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    write_keys({$urandom, $urandom}, {$urandom, $urandom});
    queue_random(60);
    drain();

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #(8_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
